// ===== rtl/radix_digit_extractor_defines.svh =====
// Assertion macros for the radix digit extractor.
// Used by the top level; expects clk and rst_n in scope at the point of use.
`ifndef RADIX_DIGIT_EXTRACTOR_DEFINES_SVH
`define RADIX_DIGIT_EXTRACTOR_DEFINES_SVH

`define RDE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rde_pkg.sv =====
// Shared types and constants of the radix digit extractor.
// Depends on nothing; used by the front end, the back end and the top level.
package rde_pkg;

    localparam int VALUE_W     = 31;
    localparam int DIGIT_W     = 4;
    localparam int SUM_W       = 8;
    localparam int RADIX_W     = 5;
    localparam int MAX_RESULTS = 31;

    localparam int DIV_W      = 32;
    localparam int DIV_BITS   = 8;
    localparam int DIV_CYCLES = DIV_W / DIV_BITS;
    localparam int STEP_W     = $clog2(DIV_CYCLES);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic {
        REG_RADIX     = 1'b0,
        REG_MSD_FIRST = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] base;
        logic               msd_first;
        logic               zero;
    } item_t;

    function automatic logic [RADIX_W-1:0] sat_base(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] b;
        b = r;
        if (r < RADIX_MIN) begin
            b = RADIX_MIN;
        end
        else if (r > RADIX_MAX) begin
            b = RADIX_MAX;
        end
        return b;
    endfunction

endpackage

// ===== rtl/rde_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rde_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rde_front.sv =====
// Front end: accepts values, classifies them and queues them for the back end.
// Depends on rde_pkg.
module rde_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [rde_pkg::VALUE_W-1:0]   value,
    input  logic [rde_pkg::RADIX_W-1:0]   radix,
    input  logic                          msd_first,
    output rde_pkg::item_t                item,
    output logic                          item_valid,
    input  logic                          item_take
);

    rde_pkg::item_t q_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           push_ok;
    logic           take_ok;
    rde_pkg::item_t new_item;

    assign full       = (cnt_reg == 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];
    assign push_ok    = push && !full;
    assign take_ok    = item_take && item_valid;

    always_comb
    begin
        new_item.value     = value;
        new_item.base      = rde_pkg::sat_base(radix);
        new_item.msd_first = msd_first;
        new_item.zero      = (value == '0);
    end

    always_comb
    begin
        wr_ptr_next = push_ok ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take_ok ? !rd_ptr_reg : rd_ptr_reg;
        case ({push_ok, take_ok})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== rtl/rde_back.sv =====
// Back end: iterative division by the base, digit buffering and result register.
// Depends on rde_pkg and rde_ram.
module rde_back #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rde_pkg::item_t                item,
    input  logic                          item_valid,
    output logic                          item_take,
    output logic [rde_pkg::DIGIT_W-1:0]   digit,
    output logic [rde_pkg::SUM_W-1:0]     digit_sum,
    output logic                          last,
    output logic                          empty,
    input  logic                          pop
);

    localparam int LIMIT = (MAX_DIGITS < rde_pkg::MAX_RESULTS) ? MAX_DIGITS
                                                               : rde_pkg::MAX_RESULTS;
    localparam int CW = $clog2(LIMIT + 1);
    localparam int AW = $clog2(LIMIT);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_DIV     = 5'b00010,
        ST_EMIT    = 5'b00100,
        ST_RD_ADDR = 5'b01000,
        ST_RD_DATA = 5'b10000
    } back_state_t;

    back_state_t                     state_reg, state_next;
    logic [rde_pkg::DIV_W-1:0]       work_reg, work_next, work_c;
    logic [rde_pkg::DIGIT_W-1:0]     rem_reg, rem_next, rem_c;
    logic [rde_pkg::RADIX_W-1:0]     base_reg, base_next;
    logic                            msd_reg, msd_next;
    logic [rde_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [CW-1:0]                   count_reg, count_next, cnt_new;
    logic [rde_pkg::SUM_W-1:0]       sum_reg, sum_next, sum_new;
    logic [AW-1:0]                   idx_reg, idx_next;
    logic [rde_pkg::DIGIT_W-1:0]     dig_reg, dig_next;
    logic                            fin_reg, fin_next;
    logic                            last_digit;
    logic [rde_pkg::DIGIT_W:0]       trial;

    logic                            out_v_reg, out_v_next;
    logic [rde_pkg::DIGIT_W-1:0]     out_digit_reg, out_digit_next;
    logic [rde_pkg::SUM_W-1:0]       out_sum_reg, out_sum_next;
    logic                            out_last_reg, out_last_next;
    logic                            out_load;
    logic                            slot_free;

    logic                            ram_we;
    logic                            ram_re;
    logic [rde_pkg::DIGIT_W-1:0]     ram_rdata;

    rde_ram #(
        .WIDTH (rde_pkg::DIGIT_W),
        .DEPTH (LIMIT)
    ) u_digit_buffer (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (rem_c),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign slot_free = !out_v_reg || pop;

    always_comb
    begin
        rem_c  = rem_reg;
        work_c = work_reg;
        trial  = '0;
        for (int i = 0; i < rde_pkg::DIV_BITS; i++)
        begin
            trial = {rem_c, work_c[rde_pkg::DIV_W-1]};
            if (trial >= base_reg)
            begin
                trial  = trial - base_reg;
                work_c = {work_c[rde_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                work_c = {work_c[rde_pkg::DIV_W-2:0], 1'b0};
            end
            rem_c = trial[rde_pkg::DIGIT_W-1:0];
        end
        sum_new    = sum_reg + {{(rde_pkg::SUM_W - rde_pkg::DIGIT_W){1'b0}}, rem_c};
        cnt_new    = count_reg + CW'(1);
        last_digit = (work_c == '0) || (cnt_new == CW'(LIMIT));
    end

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        base_next      = base_reg;
        msd_next       = msd_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        idx_next       = idx_reg;
        dig_next       = dig_reg;
        fin_next       = fin_reg;
        item_take      = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        out_load       = 1'b0;
        out_digit_next = out_digit_reg;
        out_sum_next   = out_sum_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_take  = 1'b1;
                    base_next  = item.base;
                    msd_next   = item.msd_first;
                    work_next  = {1'b0, item.value};
                    rem_next   = '0;
                    step_next  = '0;
                    count_next = '0;
                    sum_next   = '0;
                    dig_next   = '0;
                    fin_next   = 1'b1;
                    state_next = item.zero ? ST_EMIT : ST_DIV;
                end
            end
            ST_DIV:
            begin
                work_next = work_c;
                rem_next  = rem_c;
                step_next = step_reg + rde_pkg::STEP_W'(1);
                if (step_reg == rde_pkg::STEP_W'(rde_pkg::DIV_CYCLES - 1))
                begin
                    rem_next   = '0;
                    step_next  = '0;
                    sum_next   = sum_new;
                    count_next = cnt_new;
                    if (msd_reg)
                    begin
                        ram_we = 1'b1;
                        if (last_digit)
                        begin
                            idx_next   = count_reg[AW-1:0];
                            state_next = ST_RD_ADDR;
                        end
                    end
                    else
                    begin
                        dig_next   = rem_c;
                        fin_next   = last_digit;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_load       = 1'b1;
                    out_digit_next = dig_reg;
                    out_last_next  = fin_reg;
                    out_sum_next   = fin_reg ? sum_reg : '0;
                    state_next     = fin_reg ? ST_IDLE : ST_DIV;
                end
            end
            ST_RD_ADDR:
            begin
                ram_re     = 1'b1;
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                if (slot_free)
                begin
                    out_load       = 1'b1;
                    out_digit_next = ram_rdata;
                    out_last_next  = (idx_reg == '0);
                    out_sum_next   = (idx_reg == '0) ? sum_reg : '0;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - AW'(1);
                        state_next = ST_RD_ADDR;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_v_next = 1'b1;
        end
        else if (pop)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
            step_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg      <= work_next;
        rem_reg       <= rem_next;
        base_reg      <= base_next;
        msd_reg       <= msd_next;
        sum_reg       <= sum_next;
        dig_reg       <= dig_next;
        fin_reg       <= fin_next;
        out_digit_reg <= out_digit_next;
        out_sum_reg   <= out_sum_next;
        out_last_reg  <= out_last_next;
    end

    assign empty     = !out_v_reg;
    assign digit     = out_digit_reg;
    assign digit_sum = out_sum_reg;
    assign last      = out_last_reg;

endmodule

// ===== rtl/radix_digit_extractor.sv =====
// Splits each 31-bit value into digits of the configured base (2 to 16, out-of-range
// settings saturate) and returns one result per digit; the last result of a value carries
// the digit sum. A value is divided by the base 8 quotient bits per cycle in the shared
// divider. Most significant first: digits go into the digit buffer, then are read back
// through its registered read port. Zero gives one result.
// Two values can wait in the input queue while one is being split.
`include "radix_digit_extractor_defines.svh"

module radix_digit_extractor #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [rde_pkg::VALUE_W-1:0]        value,
    output logic                               empty,
    input  logic                               pop,
    output logic [rde_pkg::DIGIT_W-1:0]        digit,
    output logic [rde_pkg::SUM_W-1:0]          digit_sum,
    output logic                               last,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rde_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rde_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rde_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    logic [rde_pkg::RADIX_W-1:0] radix_reg, radix_next;
    logic                        msd_first_reg, msd_first_next;
    logic                        cfg_wr;
    rde_pkg::reg_idx_t           reg_idx;
    rde_pkg::item_t              item;
    logic                        item_valid;
    logic                        item_take;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = rde_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        radix_next     = radix_reg;
        msd_first_next = msd_first_reg;
        prdata         = '0;
        case (reg_idx)
            rde_pkg::REG_RADIX:
            begin
                prdata = {{(rde_pkg::APB_DATA_W - rde_pkg::RADIX_W){1'b0}}, radix_reg};
                if (cfg_wr)
                begin
                    radix_next = pwdata[rde_pkg::RADIX_W-1:0];
                end
            end
            rde_pkg::REG_MSD_FIRST:
            begin
                prdata = {{(rde_pkg::APB_DATA_W - 1){1'b0}}, msd_first_reg};
                if (cfg_wr)
                begin
                    msd_first_next = pwdata[0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= rde_pkg::RADIX_RESET;
            msd_first_reg <= 1'b0;
        end
        else
        begin
            radix_reg     <= radix_next;
            msd_first_reg <= msd_first_next;
        end
    end

    rde_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .value      (value),
        .radix      (radix_reg),
        .msd_first  (msd_first_reg),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take)
    );

    rde_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .digit      (digit),
        .digit_sum  (digit_sum),
        .last       (last),
        .empty      (empty),
        .pop        (pop)
    );

    `RDE_ASSERT_SAME(a_sum_only_on_last, !empty && !last, digit_sum == '0, "sum on a non-final digit")
    `RDE_ASSERT_SAME(a_zero_sum_zero_digit, !empty && last && digit_sum == '0, digit == '0, "zero sum with nonzero digit")
    `RDE_ASSERT_SAME(a_base_in_range, item_valid, item.base >= rde_pkg::RADIX_MIN && item.base <= rde_pkg::RADIX_MAX, "queued base out of range")
    `RDE_ASSERT_NEXT(a_push_queues, push && !full, item_valid, "accepted value not queued")

endmodule
